// ===== design/oois_pkg.sv =====
`default_nettype none
package oois_pkg;

  // Sizes
  localparam int ROB_DEPTH   = 32;
  localparam int ROB_IW      = 5;
  localparam int ROB_CW      = 6;
  localparam int SCHED_DEPTH = 32;
  localparam int MAX_WIDTH   = 8;
  localparam int DSP_DEPTH   = 2 * MAX_WIDTH;
  localparam int DSP_IW      = 4;
  localparam int DSP_CW      = 5;
  localparam int NUM_REGS    = 128;
  localparam int REG_IW      = 7;
  localparam int RETIRE_MAX  = 32;
  localparam int CYC_W       = 32;
  localparam int TAG_W       = 16;
  localparam int NSTAMP      = 5;

  // Pipeline stage codes
  localparam logic [2:0] ST_IF = 3'd0;
  localparam logic [2:0] ST_ID = 3'd1;
  localparam logic [2:0] ST_IS = 3'd2;
  localparam logic [2:0] ST_EX = 3'd3;
  localparam logic [2:0] ST_WB = 3'd4;

  // Stamp slots
  localparam int SLOT_IF = 0;
  localparam int SLOT_ID = 1;
  localparam int SLOT_IS = 2;
  localparam int SLOT_EX = 3;
  localparam int SLOT_WB = 4;

  // Result kinds
  localparam logic [1:0] RK_FETCH_OK  = 2'd0;
  localparam logic [1:0] RK_FETCH_REF = 2'd1;
  localparam logic [1:0] RK_RETIRE    = 2'd2;
  localparam logic [1:0] RK_TICK      = 2'd3;

  // Config register indexes
  localparam logic [1:0] CFG_QUEUE_SIZE = 2'd0;
  localparam logic [1:0] CFG_WIDTH      = 2'd1;

  // Op types
  localparam logic [1:0] OP_LAT1 = 2'd0;
  localparam logic [1:0] OP_LAT2 = 2'd1;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [1:0]       op;
    logic [7:0]       src1;
    logic [7:0]       src2;
    logic [7:0]       dest;
  } info_t;

  typedef struct packed {
    logic              info_we;
    logic [NSTAMP-1:0] stamp_we;
    logic [ROB_IW-1:0] addr;
    info_t             info;
    logic [CYC_W-1:0]  stamp;
  } rec_wr_t;

  typedef struct packed {
    logic [REG_IW-1:0] rd_addr;
    logic              set_en;
    logic [REG_IW-1:0] set_addr;
    logic [ROB_IW-1:0] set_owner;
    logic              clr_en;
    logic [REG_IW-1:0] clr_addr;
  } sb_req_t;

  function automatic logic [2:0] lat_of(input logic [1:0] op);
    logic [2:0] l;
    case (op)
      OP_LAT1: l = 3'd1;
      OP_LAT2: l = 3'd2;
      default: l = 3'd5;
    endcase
    return l;
  endfunction

  // register number in scoreboard range (negative values have bit 7 set)
  function automatic logic reg_ok(input logic [7:0] raw);
    return ~raw[7];
  endfunction

endpackage
`default_nettype wire

// ===== design/oois_scoreboard.sv =====
`default_nettype none
module oois_scoreboard
  import oois_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sb_req_t           req_i,
  output logic                   busy_rd_o,
  output logic [ROB_IW-1:0]      owner_rd_o
);

  logic [NUM_REGS-1:0] busy_q;
  logic [ROB_IW-1:0]   owner_mem [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      busy_rd_o <= 1'b0;
    end else begin
      busy_rd_o <= busy_q[req_i.rd_addr];
      if (req_i.set_en) begin
        busy_q[req_i.set_addr] <= 1'b1;
      end
      if (req_i.clr_en) begin
        busy_q[req_i.clr_addr] <= 1'b0;
      end
    end
  end

  // owner table: no reset, only read where busy
  always_ff @(posedge clk_i) begin
    if (req_i.set_en) begin
      owner_mem[req_i.set_addr] <= req_i.set_owner;
    end
    owner_rd_o <= owner_mem[req_i.rd_addr];
  end

endmodule
`default_nettype wire

// ===== design/oois_rec_mem.sv =====
`default_nettype none
module oois_rec_mem
  import oois_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire rec_wr_t                 wr_i,
  input  wire logic [ROB_IW-1:0]       rd_addr_i,
  output info_t                        info_rd_o,
  output logic [NSTAMP-1:0][CYC_W-1:0] stamp_rd_o
);

  info_t            info_mem  [ROB_DEPTH];
  logic [CYC_W-1:0] stamp_mem [NSTAMP][ROB_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.info_we) begin
      info_mem[wr_i.addr] <= wr_i.info;
    end
    info_rd_o <= info_mem[rd_addr_i];
    for (int f = 0; f < NSTAMP; f++) begin
      if (wr_i.stamp_we[f]) begin
        stamp_mem[f][wr_i.addr] <= wr_i.stamp;
      end
      stamp_rd_o[f] <= stamp_mem[f][rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/out_of_order_issue_scheduler_core.sv =====
// Out-of-order issue scheduler, timing model of a superscalar pipeline.
// Fetch word: states F0 to F3 from accept to result (three scoreboard reads, one write);
//   a refused fetch answers from F0.
// Tick word: advance cycle, retire up to RETIRE_MAX records, scan live ROB entries
//   for completion, wake, issue scan of queue entries, dispatch, mark scan.
// One word in flight; the sequencer and its single entry port set the rate.
// Reset (async, active low): empty ROB and queues, cycle 0, scoreboard clear.
`default_nettype none
module out_of_order_issue_scheduler_core
  import oois_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // config
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_addr_i,
  input  wire logic [5:0]        cfg_wdata_i,
  // input words
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              kind_i,
  input  wire logic [1:0]        unit_type_i,
  input  wire logic signed [7:0] dest_reg_i,
  input  wire logic signed [7:0] src1_reg_i,
  input  wire logic signed [7:0] src2_reg_i,
  // result words
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             result_kind_o,
  output logic [TAG_W-1:0]       seq_tag_o,
  output logic [1:0]             op_type_o,
  output logic signed [7:0]      out_src1_o,
  output logic signed [7:0]      out_src2_o,
  output logic signed [7:0]      out_dest_o,
  output logic [CYC_W-1:0]       fetch_cycle_o,
  output logic [CYC_W-1:0]       decode_cycle_o,
  output logic [CYC_W-1:0]       queue_cycle_o,
  output logic [CYC_W-1:0]       exec_cycle_o,
  output logic [CYC_W-1:0]       done_cycle_o,
  output logic                   last_o
);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_F0   = 4'd1;  // refusal check, read owner of src1
  localparam logic [3:0] S_F1   = 4'd2;
  localparam logic [3:0] S_F2   = 4'd3;
  localparam logic [3:0] S_F3   = 4'd4;  // allocate entry, claim dest
  localparam logic [3:0] S_T0   = 4'd5;  // advance cycle
  localparam logic [3:0] S_TRD  = 4'd6;  // record read of ROB head
  localparam logic [3:0] S_TRET = 4'd7;  // retire head if in WB
  localparam logic [3:0] S_CMP  = 4'd8;  // completion scan over live entries
  localparam logic [3:0] S_WAKE = 4'd9;  // wake dependents of completed entries
  localparam logic [3:0] S_ISS  = 4'd10; // issue scan over scheduling queue
  localparam logic [3:0] S_DSP  = 4'd11; // move dispatch head into queue
  localparam logic [3:0] S_MRK  = 4'd12; // mark fetched entries as decoded
  localparam logic [3:0] S_ETK  = 4'd13; // emit cycle-done word

  logic [3:0] state_q;

  // Config
  logic [5:0] qsz_q;
  logic [3:0] wid_q;
  logic [3:0] eff_w;
  logic [4:0] eff_w2;
  logic [5:0] eff_qs;

  // Captured input word
  logic [1:0] op_q;
  logic [7:0] d_q, s1_q, s2_q;

  // Global counters
  logic [CYC_W-1:0]  cyc_q;
  logic [TAG_W-1:0]  tag_q;
  logic [3:0]        fetched_q;
  logic [ROB_IW-1:0] head_q;
  logic [ROB_CW-1:0] cnt_q;
  logic [DSP_CW-1:0] dcnt_q;
  logic [ROB_CW-1:0] scnt_q;
  logic [ROB_CW-1:0] scan_q;
  logic [ROB_CW-1:0] keep_q;
  logic [3:0]        took_q;
  logic [ROB_CW-1:0] nret_q;
  logic [ROB_DEPTH-1:0] done_q;

  // Source waits gathered during fetch
  logic              fw1v_q, fw2v_q;
  logic [ROB_IW-1:0] fw1i_q, fw2i_q;

  // Per-entry control (no reset; only live entries are read)
  logic [2:0]        stage_q [ROB_DEPTH];
  logic [2:0]        lat_q   [ROB_DEPTH];
  logic              w1v_q   [ROB_DEPTH];
  logic              w2v_q   [ROB_DEPTH];
  logic [ROB_IW-1:0] w1i_q   [ROB_DEPTH];
  logic [ROB_IW-1:0] w2i_q   [ROB_DEPTH];
  logic              dval_q  [ROB_DEPTH];
  logic [REG_IW-1:0] dreg_q  [ROB_DEPTH];
  logic              owns_q  [ROB_DEPTH];  // still the scoreboard owner of dest

  logic [ROB_IW-1:0] sq_q [SCHED_DEPTH];
  logic [ROB_IW-1:0] dl_q [DSP_DEPTH];

  // Output register
  logic              out_valid_q;
  logic              out_free;
  logic              out_load;

  // Submodule links
  sb_req_t           sb_req;
  logic              sb_busy;
  logic [ROB_IW-1:0] sb_owner;
  rec_wr_t           rec_wr;
  info_t             rec_info;
  logic [NSTAMP-1:0][CYC_W-1:0] rec_stamp;

  // Shared entry port
  logic [ROB_IW-1:0] tail;
  logic [ROB_IW-1:0] sel;
  logic [2:0]        sel_stage;
  logic [2:0]        sel_lat;

  logic refuse, fet_go, ret_ok, ret_go;
  logic cmp_act, cmp_ex, cmp_fin;
  logic iss_act, iss_go, dsp_go, mrk_act, mrk_go;

  assign eff_w  = (wid_q == 4'd0) ? 4'd1 :
                  (wid_q > 4'(MAX_WIDTH)) ? 4'(MAX_WIDTH) : wid_q;
  assign eff_w2 = {eff_w, 1'b0};
  assign eff_qs = (qsz_q == 6'd0) ? 6'd1 :
                  (qsz_q > 6'(SCHED_DEPTH)) ? 6'(SCHED_DEPTH) : qsz_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign tail       = head_q + cnt_q[ROB_IW-1:0];

  always_comb begin
    case (state_q)
      S_F3:    sel = tail;
      S_CMP:   sel = head_q + scan_q[ROB_IW-1:0];
      S_ISS:   sel = sq_q[scan_q[ROB_IW-1:0]];
      S_DSP:   sel = dl_q[0];
      S_MRK:   sel = dl_q[scan_q[DSP_IW-1:0]];
      default: sel = head_q;
    endcase
  end
  assign sel_stage = stage_q[sel];
  assign sel_lat   = lat_q[sel];

  assign refuse  = (dcnt_q >= eff_w2) || (fetched_q >= eff_w) || (cnt_q >= 6'(ROB_DEPTH));
  assign fet_go  = (state_q == S_F3) && out_free;
  assign ret_ok  = (state_q == S_TRET) && (cnt_q != '0) &&
                   (nret_q < 6'(RETIRE_MAX)) && (sel_stage == ST_WB);
  assign ret_go  = ret_ok && out_free;
  assign cmp_act = (state_q == S_CMP) && (scan_q < cnt_q);
  assign cmp_ex  = cmp_act && (sel_stage == ST_EX);
  assign cmp_fin = cmp_ex && (sel_lat == 3'd0);
  assign iss_act = (state_q == S_ISS) && (scan_q < scnt_q);
  assign iss_go  = iss_act && (took_q < eff_w) && !w1v_q[sel] && !w2v_q[sel];
  assign dsp_go  = (state_q == S_DSP) && (dcnt_q != '0) && (scnt_q < eff_qs) &&
                   (sel_stage == ST_ID);
  assign mrk_act = (state_q == S_MRK) && (scan_q < {1'b0, dcnt_q}) && (took_q < eff_w);
  assign mrk_go  = mrk_act && (sel_stage == ST_IF);

  // any word loaded into the output register this cycle
  assign out_load = ret_go || fet_go ||
                    (out_free && (((state_q == S_F0) && refuse) || (state_q == S_ETK)));

  // Scoreboard requests
  always_comb begin
    case (state_q)
      S_F0:    sb_req.rd_addr = s1_q[REG_IW-1:0];
      S_F1:    sb_req.rd_addr = s2_q[REG_IW-1:0];
      default: sb_req.rd_addr = d_q[REG_IW-1:0];
    endcase
    sb_req.set_en    = fet_go && reg_ok(d_q);
    sb_req.set_addr  = d_q[REG_IW-1:0];
    sb_req.set_owner = tail;
    sb_req.clr_en    = cmp_fin && dval_q[sel] && owns_q[sel];
    sb_req.clr_addr  = dreg_q[sel];
  end

  // Record memory writes: all stamps take the current cycle
  always_comb begin
    rec_wr.info_we  = fet_go;
    rec_wr.stamp_we = '0;
    rec_wr.stamp_we[SLOT_IF] = fet_go;
    rec_wr.stamp_we[SLOT_ID] = mrk_go;
    rec_wr.stamp_we[SLOT_IS] = dsp_go;
    rec_wr.stamp_we[SLOT_EX] = iss_go;
    rec_wr.stamp_we[SLOT_WB] = cmp_fin;
    rec_wr.addr      = sel;
    rec_wr.info.tag  = tag_q;
    rec_wr.info.op   = op_q;
    rec_wr.info.src1 = s1_q;
    rec_wr.info.src2 = s2_q;
    rec_wr.info.dest = d_q;
    rec_wr.stamp     = cyc_q;
  end

  oois_scoreboard u_sb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (sb_req),
    .busy_rd_o  (sb_busy),
    .owner_rd_o (sb_owner)
  );

  oois_rec_mem u_rec (
    .clk_i      (clk_i),
    .wr_i       (rec_wr),
    .rd_addr_i  (head_q),
    .info_rd_o  (rec_info),
    .stamp_rd_o (rec_stamp)
  );

  // Input capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= unit_type_i;
      d_q  <= dest_reg_i;
      s1_q <= src1_reg_i;
      s2_q <= src2_reg_i;
    end
    if (state_q == S_F1) begin
      fw1v_q <= reg_ok(s1_q) && sb_busy;
      fw1i_q <= sb_owner;
    end
    if (state_q == S_F2) begin
      fw2v_q <= reg_ok(s2_q) && sb_busy;
      fw2i_q <= sb_owner;
    end
  end

  // Per-entry arrays and queues
  always_ff @(posedge clk_i) begin
    if (fet_go) begin
      // the previous live owner of dest loses ownership
      if (reg_ok(d_q) && sb_busy) begin
        owns_q[sb_owner] <= 1'b0;
      end
      stage_q[sel] <= ST_IF;
      lat_q[sel]   <= lat_of(op_q);
      w1v_q[sel]   <= fw1v_q;
      w1i_q[sel]   <= fw1i_q;
      w2v_q[sel]   <= fw2v_q;
      w2i_q[sel]   <= fw2i_q;
      dval_q[sel]  <= reg_ok(d_q);
      dreg_q[sel]  <= d_q[REG_IW-1:0];
      owns_q[sel]  <= reg_ok(d_q);
      dl_q[dcnt_q[DSP_IW-1:0]] <= sel;
    end
    if (cmp_ex) begin
      if (cmp_fin) begin
        stage_q[sel] <= ST_WB;
      end else begin
        lat_q[sel] <= sel_lat - 3'd1;
      end
    end
    if (state_q == S_WAKE) begin
      for (int i = 0; i < ROB_DEPTH; i++) begin
        if (w1v_q[i] && done_q[w1i_q[i]]) w1v_q[i] <= 1'b0;
        if (w2v_q[i] && done_q[w2i_q[i]]) w2v_q[i] <= 1'b0;
      end
    end
    if (iss_act) begin
      if (iss_go) begin
        stage_q[sel] <= ST_EX;
        if (sel_lat != 3'd0) lat_q[sel] <= sel_lat - 3'd1;
      end else begin
        sq_q[keep_q[ROB_IW-1:0]] <= sel;
      end
    end
    if (dsp_go) begin
      stage_q[sel] <= ST_IS;
      sq_q[scnt_q[ROB_IW-1:0]] <= sel;
      for (int i = 0; i < DSP_DEPTH - 1; i++) begin
        dl_q[i] <= dl_q[i+1];
      end
    end
    if (mrk_go) begin
      stage_q[sel] <= ST_ID;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (ret_go) begin
      result_kind_o  <= RK_RETIRE;
      seq_tag_o      <= rec_info.tag;
      op_type_o      <= rec_info.op;
      out_src1_o     <= rec_info.src1;
      out_src2_o     <= rec_info.src2;
      out_dest_o     <= rec_info.dest;
      fetch_cycle_o  <= rec_stamp[SLOT_IF];
      decode_cycle_o <= rec_stamp[SLOT_ID];
      queue_cycle_o  <= rec_stamp[SLOT_IS];
      exec_cycle_o   <= rec_stamp[SLOT_EX];
      done_cycle_o   <= rec_stamp[SLOT_WB];
      last_o         <= 1'b0;
    end else if (fet_go) begin
      result_kind_o  <= RK_FETCH_OK;
      seq_tag_o      <= tag_q;
      op_type_o      <= op_q;
      out_src1_o     <= s1_q;
      out_src2_o     <= s2_q;
      out_dest_o     <= d_q;
      fetch_cycle_o  <= cyc_q;
      decode_cycle_o <= '0;
      queue_cycle_o  <= '0;
      exec_cycle_o   <= '0;
      done_cycle_o   <= '0;
      last_o         <= 1'b1;
    end else if (out_free && (((state_q == S_F0) && refuse) || (state_q == S_ETK))) begin
      result_kind_o  <= (state_q == S_ETK) ? RK_TICK : RK_FETCH_REF;
      seq_tag_o      <= '0;
      op_type_o      <= '0;
      out_src1_o     <= '0;
      out_src2_o     <= '0;
      out_dest_o     <= '0;
      fetch_cycle_o  <= cyc_q;
      decode_cycle_o <= '0;
      queue_cycle_o  <= '0;
      exec_cycle_o   <= '0;
      done_cycle_o   <= '0;
      last_o         <= 1'b1;
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      qsz_q       <= 6'd8;
      wid_q       <= 4'd2;
      cyc_q       <= '0;
      tag_q       <= '0;
      fetched_q   <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      scnt_q      <= '0;
      scan_q      <= '0;
      keep_q      <= '0;
      took_q      <= '0;
      nret_q      <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmp_fin) done_q[sel] <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            if (cfg_addr_i == CFG_QUEUE_SIZE) qsz_q <= cfg_wdata_i;
            else if (cfg_addr_i == CFG_WIDTH) wid_q <= cfg_wdata_i[3:0];
          end
          if (in_valid_i) state_q <= kind_i ? S_T0 : S_F0;
        end
        S_F0: begin
          if (!refuse) begin
            state_q <= S_F1;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_F1: state_q <= S_F2;
        S_F2: state_q <= S_F3;
        S_F3: begin
          if (fet_go) begin
            cnt_q     <= cnt_q + 6'd1;
            dcnt_q    <= dcnt_q + 5'd1;
            fetched_q <= fetched_q + 4'd1;
            tag_q     <= tag_q + 16'd1;
            state_q   <= S_IDLE;
          end
        end
        S_T0: begin
          cyc_q     <= cyc_q + 32'd1;
          fetched_q <= '0;
          nret_q    <= '0;
          state_q   <= S_TRD;
        end
        S_TRD: state_q <= S_TRET;
        S_TRET: begin
          if (ret_go) begin
            head_q  <= head_q + 5'd1;
            cnt_q   <= cnt_q - 6'd1;
            nret_q  <= nret_q + 6'd1;
            state_q <= S_TRD;
          end else if (!ret_ok) begin
            scan_q  <= '0;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (cmp_act) scan_q <= scan_q + 6'd1;
          else state_q <= S_WAKE;
        end
        S_WAKE: begin
          done_q  <= '0;
          scan_q  <= '0;
          keep_q  <= '0;
          took_q  <= '0;
          state_q <= S_ISS;
        end
        S_ISS: begin
          if (iss_act) begin
            scan_q <= scan_q + 6'd1;
            if (iss_go) took_q <= took_q + 4'd1;
            else keep_q <= keep_q + 6'd1;
          end else begin
            scnt_q  <= keep_q;
            state_q <= S_DSP;
          end
        end
        S_DSP: begin
          if (dsp_go) begin
            scnt_q <= scnt_q + 6'd1;
            dcnt_q <= dcnt_q - 5'd1;
          end else begin
            scan_q  <= '0;
            took_q  <= '0;
            state_q <= S_MRK;
          end
        end
        S_MRK: begin
          if (mrk_act) begin
            scan_q <= scan_q + 6'd1;
            if (mrk_go) took_q <= took_q + 4'd1;
          end else begin
            state_q <= S_ETK;
          end
        end
        S_ETK: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_rob_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 6'(ROB_DEPTH))
    else $error("ROB occupancy over depth");

  a_queues_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (7'(scnt_q) + 7'(dcnt_q)) <= 7'(cnt_q))
    else $error("queue entries exceed live ROB entries");

  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (done_q == '0))
    else $error("completion mask left set");

  a_fetch_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fet_go |=> (cnt_q == $past(cnt_q) + 6'd1))
    else $error("fetch did not allocate ROB entry");

endmodule
`default_nettype wire
